[design/gbs_pkg.sv]
// Package: shared constants, types and helpers for the background subtractor.
package gbs_pkg;

  // Frame geometry and field widths
  localparam int FRAME_PIXELS = 307200;
  localparam int MEM_AW       = $clog2(FRAME_PIXELS);
  localparam int ADDR_W       = 19;
  localparam int PIX_W        = 8;
  localparam int SUM_W        = 14;
  localparam int SQ_W         = 22;
  localparam int MEAN_W       = 8;
  localparam int TH_W         = 18;
  localparam int N_W          = 7;
  localparam int GAIN_W       = 8;
  localparam int MASK_W       = 8;

  // Pipelined divider geometry
  localparam int DIV_W        = 28;
  localparam int DEN_W        = 7;
  localparam int DIV_TAG_W    = SQ_W + SUM_W + ADDR_W;

  // Derived arithmetic widths
  localparam int DEV_W        = 24;
  localparam int PROD_W       = GAIN_W + DEV_W;

  // Register map
  localparam logic       REG_LEARN_FRAMES = 1'b0;
  localparam logic       REG_GAIN_Q4      = 1'b1;
  localparam int         APB_AW           = 3;
  localparam logic [N_W-1:0]    LEARN_RESET = 7'd50;
  localparam logic [GAIN_W-1:0] GAIN_RESET  = 8'd40;
  localparam logic [N_W-1:0]    N_MAX       = 7'd64;

  localparam logic [MASK_W-1:0] MASK_FG = 8'd255;
  localparam logic [MASK_W-1:0] MASK_BG = 8'd0;

  // Per-pixel phase, chosen from the frame count at accept time
  typedef enum logic [1:0] {
    PH_LEARN,
    PH_FINAL,
    PH_CLASS
  } phase_t;

  // Finalize request from the read stage
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [SUM_W-1:0]  sum;
    logic [SQ_W-1:0]   sq;
    logic [N_W-1:0]    n;
    logic [GAIN_W-1:0] gain;
  } fin_req_t;

  // Model write produced by the finalize pipeline
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [MEAN_W-1:0] mean;
    logic [TH_W-1:0]   th;
  } fin_wr_t;

  // Effective learn count: 0 acts as 1, above 64 acts as 64
  function automatic logic [N_W-1:0] eff_frames(input logic [N_W-1:0] lf);
    logic [N_W-1:0] r;
    if (lf == '0) r = N_W'(1);
    else if (lf > N_MAX) r = N_MAX;
    else r = lf;
    return r;
  endfunction

endpackage

[design/gbs_stream_if.sv]
// Interfaces: pixel input channel and mask output channel.
interface gbs_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [gbs_pkg::PIX_W-1:0]  pixel_value;
  logic [gbs_pkg::ADDR_W-1:0] pixel_addr;
  logic                       end_of_frame;

  modport source (output valid, pixel_value, pixel_addr, end_of_frame, input ready);
  modport sink   (input valid, pixel_value, pixel_addr, end_of_frame, output ready);
endinterface

interface gbs_mask_if;
  logic                       valid;
  logic                       ready;
  logic [gbs_pkg::MASK_W-1:0] mask_value;
  logic [gbs_pkg::ADDR_W-1:0] mask_addr;

  modport source (output valid, mask_value, mask_addr, input ready);
  modport sink   (input valid, mask_value, mask_addr, output ready);
endinterface

[design/gbs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module gbs_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/gbs_div.sv]
// Pipelined restoring divider: one quotient bit per stage, one beat per cycle.
module gbs_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [gbs_pkg::DIV_W-1:0]     in_num,
  input  logic [gbs_pkg::DEN_W-1:0]     in_den,
  input  logic [gbs_pkg::DIV_TAG_W-1:0] in_tag,
  output logic                          out_valid,
  output logic [gbs_pkg::DIV_W-1:0]     out_quo,
  output logic [gbs_pkg::DIV_TAG_W-1:0] out_tag,
  output logic                          busy
);

  localparam int W = gbs_pkg::DIV_W;
  localparam int D = gbs_pkg::DEN_W;

  // Stage 0 is the input; stage k holds the beat after k quotient bits
  logic                          v   [W+1];
  logic [D-1:0]                  rem [W+1];
  logic [W-1:0]                  num [W+1];
  logic [D-1:0]                  den [W+1];
  logic [gbs_pkg::DIV_TAG_W-1:0] tag [W+1];
  logic [W:0]                    v_vec;

  assign v[0]   = in_valid;
  assign rem[0] = '0;
  assign num[0] = in_num;
  assign den[0] = in_den;
  assign tag[0] = in_tag;

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [D:0] trial;
    logic       ge;

    // Shift in the next dividend bit and try a subtract
    assign trial = {rem[k], num[k][W-1]};
    assign ge    = trial >= {1'b0, den[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      rem[k+1] <= ge ? D'(trial - {1'b0, den[k]}) : trial[D-1:0];
      num[k+1] <= {num[k][W-2:0], ge};
      den[k+1] <= den[k];
      tag[k+1] <= tag[k];
    end
  end

  for (genvar k = 0; k <= W; k++) begin : g_vec
    assign v_vec[k] = v[k];
  end

  assign out_valid = v[W];
  assign out_quo   = num[W];
  assign out_tag   = tag[W];
  assign busy      = |v_vec[W:1];

endmodule

[design/gbs_finalize.sv]
// Finalize pipeline: mean, deviation sum and threshold for one pixel per cycle.
module gbs_finalize (
  input  logic              clk,
  input  logic              rst,
  input  gbs_pkg::fin_req_t req,
  output gbs_pkg::fin_wr_t  wr,
  output logic              busy
);

  localparam int MW = gbs_pkg::MEAN_W;

  // Mean divider
  logic                          d1_valid;
  logic [gbs_pkg::DIV_W-1:0]     d1_quo;
  logic [gbs_pkg::DIV_TAG_W-1:0] d1_tag;
  logic                          d1_busy;

  gbs_div u_div_mean (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_num   (gbs_pkg::DIV_W'(req.sum)),
    .in_den   (req.n),
    .in_tag   ({req.sq, req.sum, req.addr}),
    .out_valid(d1_valid),
    .out_quo  (d1_quo),
    .out_tag  (d1_tag),
    .busy     (d1_busy)
  );

  // The divider does not pass n (its divisor) or gain through, so keep a side line
  logic [gbs_pkg::N_W-1:0]    side_n    [gbs_pkg::DIV_W+1];
  logic [gbs_pkg::GAIN_W-1:0] side_gain [gbs_pkg::DIV_W+1];

  assign side_n[0]    = req.n;
  assign side_gain[0] = req.gain;

  for (genvar k = 0; k < gbs_pkg::DIV_W; k++) begin : g_side
    always_ff @(posedge clk) begin
      side_n[k+1]    <= side_n[k];
      side_gain[k+1] <= side_gain[k];
    end
  end

  logic [gbs_pkg::SQ_W-1:0]   t_sq;
  logic [gbs_pkg::SUM_W-1:0]  t_sum;
  logic [gbs_pkg::ADDR_W-1:0] t_addr;
  logic [MW-1:0]              m_sat;

  assign {t_sq, t_sum, t_addr} = d1_tag;
  assign m_sat = (|d1_quo[gbs_pkg::DIV_W-1:MW]) ? '1 : d1_quo[MW-1:0];

  // Stage A: m*m and m*S
  logic                        a_v;
  logic [2*MW-1:0]             a_m2;
  logic [MW+gbs_pkg::SUM_W-1:0] a_ms;
  logic [MW-1:0]               a_m;
  logic [gbs_pkg::SQ_W-1:0]    a_q;
  logic [gbs_pkg::N_W-1:0]     a_n;
  logic [gbs_pkg::GAIN_W-1:0]  a_gain;
  logic [gbs_pkg::ADDR_W-1:0]  a_addr;

  // Stage B: n*m*m
  logic                        b_v;
  logic [2*MW+gbs_pkg::N_W-1:0] b_nm2;
  logic [MW+gbs_pkg::SUM_W-1:0] b_ms;
  logic [MW-1:0]               b_m;
  logic [gbs_pkg::SQ_W-1:0]    b_q;
  logic [gbs_pkg::N_W-1:0]     b_n;
  logic [gbs_pkg::GAIN_W-1:0]  b_gain;
  logic [gbs_pkg::ADDR_W-1:0]  b_addr;

  // Stage C: deviation sum, clamped at zero
  logic                        c_v;
  logic [gbs_pkg::DEV_W-1:0]   c_dev;
  logic [MW-1:0]               c_m;
  logic [gbs_pkg::N_W-1:0]     c_n;
  logic [gbs_pkg::GAIN_W-1:0]  c_gain;
  logic [gbs_pkg::ADDR_W-1:0]  c_addr;

  // Stage D: gain product
  logic                        d_v;
  logic [gbs_pkg::PROD_W-1:0]  d_prod;
  logic [MW-1:0]               d_m;
  logic [gbs_pkg::N_W-1:0]     d_n;
  logic [gbs_pkg::ADDR_W-1:0]  d_addr;

  logic [gbs_pkg::DEV_W:0]     c_pos;
  logic [gbs_pkg::DEV_W:0]     c_neg;

  assign c_pos = (gbs_pkg::DEV_W+1)'(b_q) + (gbs_pkg::DEV_W+1)'(b_nm2);
  assign c_neg = (gbs_pkg::DEV_W+1)'({b_ms, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
    end else begin
      a_v <= d1_valid;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    a_m2   <= m_sat * m_sat;
    a_ms   <= m_sat * t_sum;
    a_m    <= m_sat;
    a_q    <= t_sq;
    a_n    <= side_n[gbs_pkg::DIV_W];
    a_gain <= side_gain[gbs_pkg::DIV_W];
    a_addr <= t_addr;

    b_nm2  <= a_n * a_m2;
    b_ms   <= a_ms;
    b_m    <= a_m;
    b_q    <= a_q;
    b_n    <= a_n;
    b_gain <= a_gain;
    b_addr <= a_addr;

    c_dev  <= (c_pos < c_neg) ? '0 : gbs_pkg::DEV_W'(c_pos - c_neg);
    c_m    <= b_m;
    c_n    <= b_n;
    c_gain <= b_gain;
    c_addr <= b_addr;

    d_prod <= c_gain * c_dev;
    d_m    <= c_m;
    d_n    <= c_n;
    d_addr <= c_addr;
  end

  // Threshold divider: floor(prod/16) / n equals floor(prod / (16n))
  logic                          d2_valid;
  logic [gbs_pkg::DIV_W-1:0]     d2_quo;
  logic [gbs_pkg::DIV_TAG_W-1:0] d2_tag;
  logic                          d2_busy;

  gbs_div u_div_th (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d_v),
    .in_num   (d_prod[gbs_pkg::PROD_W-1:4]),
    .in_den   (d_n),
    .in_tag   (gbs_pkg::DIV_TAG_W'({d_m, d_addr})),
    .out_valid(d2_valid),
    .out_quo  (d2_quo),
    .out_tag  (d2_tag),
    .busy     (d2_busy)
  );

  always_comb begin
    wr.valid = d2_valid;
    wr.addr  = d2_tag[gbs_pkg::ADDR_W-1:0];
    wr.mean  = d2_tag[gbs_pkg::ADDR_W +: MW];
    wr.th    = (|d2_quo[gbs_pkg::DIV_W-1:gbs_pkg::TH_W]) ? '1 : d2_quo[gbs_pkg::TH_W-1:0];
  end

  assign busy = req.valid | d1_busy | a_v | b_v | c_v | d_v | d2_busy;

endmodule

[design/gaussian_background_subtractor.sv]
// Top level: single-Gaussian background subtractor on a grey pixel stream.
//
//   channel    dir  beat                                      handshake
//   pixel_in   in   pixel_value, pixel_addr, end_of_frame     valid/ready
//   mask_out   out  mask_value, mask_addr                     valid/ready
//   apb        in   learn_frames @0x0, gain_q4 @0x4           psel/penable, pready=1
//
// One pixel per cycle in every phase while ready is high. A pixel is read from the
// model RAMs at accept, updated in the next cycle and written back, with a one-entry
// bypass for the same address on consecutive beats. Finalize runs through a 60-stage
// pipeline (two 28-stage dividers); the first classify beat waits until it drains.
// After reset the sum RAM is cleared, one entry a cycle, with ready low. Results go
// through a two-entry queue; a stalled output holds ready low.
module gaussian_background_subtractor (
  input  logic                        clk,
  input  logic                        rst,
  gbs_pixel_if.sink                   pixel_in,
  gbs_mask_if.source                  mask_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gbs_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int AW  = gbs_pkg::MEM_AW;
  localparam int SQW = gbs_pkg::SUM_W + gbs_pkg::SQ_W;
  localparam int MTW = gbs_pkg::MEAN_W + gbs_pkg::TH_W;

  // Configuration registers
  logic [gbs_pkg::N_W-1:0]    learn_frames;
  logic [gbs_pkg::GAIN_W-1:0] gain_q4;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      learn_frames <= gbs_pkg::LEARN_RESET;
      gain_q4      <= gbs_pkg::GAIN_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        gbs_pkg::REG_LEARN_FRAMES: learn_frames <= pwdata[gbs_pkg::N_W-1:0];
        gbs_pkg::REG_GAIN_Q4:      gain_q4      <= pwdata[gbs_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      gbs_pkg::REG_LEARN_FRAMES: prdata = 32'(learn_frames);
      gbs_pkg::REG_GAIN_Q4:      prdata = 32'(gain_q4);
      default:                   prdata = '0;
    endcase
  end

  // Clearing pass over the sum RAM after reset
  logic          clearing;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(gbs_pkg::FRAME_PIXELS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Phase of the next beat
  logic [gbs_pkg::N_W-1:0] frame_index;
  logic [gbs_pkg::N_W-1:0] n_eff;
  gbs_pkg::phase_t         in_phase;
  logic                    in_range;

  assign n_eff    = gbs_pkg::eff_frames(learn_frames);
  assign in_range = 32'(pixel_in.pixel_addr) < gbs_pkg::FRAME_PIXELS;

  always_comb begin
    if (frame_index < n_eff) in_phase = gbs_pkg::PH_LEARN;
    else if (frame_index == n_eff) in_phase = gbs_pkg::PH_FINAL;
    else in_phase = gbs_pkg::PH_CLASS;
  end

  // Output queue occupancy and credit
  logic [1:0] q_count;
  logic       q_push;
  logic       q_pop;
  logic       credit_ok;
  logic       fin_busy;
  logic       s1_valid;
  gbs_pkg::phase_t s1_phase;
  logic       s1_class;
  logic       acc;

  assign s1_class  = s1_valid && s1_phase == gbs_pkg::PH_CLASS;
  assign q_pop     = mask_out.valid && mask_out.ready;
  assign credit_ok = (3'(q_count) - 3'(q_pop) + 3'(s1_class)) <= 3'd1;

  assign pixel_in.ready = !clearing &&
                          (in_phase != gbs_pkg::PH_CLASS || (!fin_busy && credit_ok));
  assign acc = pixel_in.valid && pixel_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_index <= '0;
    end else if (acc && pixel_in.end_of_frame && frame_index <= n_eff) begin
      frame_index <= frame_index + gbs_pkg::N_W'(1);
    end
  end

  // Read stage registers
  logic [gbs_pkg::ADDR_W-1:0] s1_addr;
  logic [gbs_pkg::PIX_W-1:0]  s1_pix;
  logic [gbs_pkg::N_W-1:0]    s1_n;
  logic                       s1_hit;
  logic [gbs_pkg::SUM_W-1:0]  byp_sum;
  logic [gbs_pkg::SQ_W-1:0]   byp_sq;
  logic [gbs_pkg::SUM_W-1:0]  new_sum;
  logic [gbs_pkg::SQ_W-1:0]   new_sq;
  logic                       s1_learn;

  assign s1_learn = s1_valid && s1_phase == gbs_pkg::PH_LEARN;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= acc && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_phase <= in_phase;
      s1_addr  <= pixel_in.pixel_addr;
      s1_pix   <= pixel_in.pixel_value;
      s1_n     <= n_eff;
      s1_hit   <= s1_learn && s1_addr == pixel_in.pixel_addr;
    end
    byp_sum <= new_sum;
    byp_sq  <= new_sq;
  end

  // Sum and square RAM
  logic [SQW-1:0]            ss_rdata;
  logic [gbs_pkg::SUM_W-1:0] cur_sum;
  logic [gbs_pkg::SQ_W-1:0]  cur_sq;
  logic [2*gbs_pkg::PIX_W-1:0] pix_sq;

  gbs_ram #(.DEPTH(gbs_pkg::FRAME_PIXELS), .WIDTH(SQW)) u_sum_ram (
    .clk  (clk),
    .we   (clearing || s1_learn),
    .waddr(clearing ? clr_addr : AW'(s1_addr)),
    .wdata(clearing ? '0 : {new_sum, new_sq}),
    .re   (acc),
    .raddr(AW'(pixel_in.pixel_addr)),
    .rdata(ss_rdata)
  );

  // Accumulate with bypass of the previous beat's write
  assign cur_sum = s1_hit ? byp_sum : ss_rdata[SQW-1:gbs_pkg::SQ_W];
  assign cur_sq  = s1_hit ? byp_sq  : ss_rdata[gbs_pkg::SQ_W-1:0];
  assign pix_sq  = s1_pix * s1_pix;
  assign new_sum = cur_sum + gbs_pkg::SUM_W'(s1_pix);
  assign new_sq  = cur_sq + gbs_pkg::SQ_W'(pix_sq);

  // Finalize pipeline
  gbs_pkg::fin_req_t fin_req;
  gbs_pkg::fin_wr_t  fin_wr;

  always_comb begin
    fin_req.valid = s1_valid && s1_phase == gbs_pkg::PH_FINAL;
    fin_req.addr  = s1_addr;
    fin_req.sum   = cur_sum;
    fin_req.sq    = cur_sq;
    fin_req.n     = s1_n;
    fin_req.gain  = gain_q4;
  end

  gbs_finalize u_finalize (
    .clk (clk),
    .rst (rst),
    .req (fin_req),
    .wr  (fin_wr),
    .busy(fin_busy)
  );

  // Mean and threshold RAM
  logic [MTW-1:0]             mt_rdata;
  logic [gbs_pkg::MEAN_W-1:0] s1_mean;
  logic [gbs_pkg::TH_W-1:0]   s1_th;
  logic [gbs_pkg::PIX_W-1:0]  diff;
  logic [gbs_pkg::MASK_W-1:0] mask_next;

  gbs_ram #(.DEPTH(gbs_pkg::FRAME_PIXELS), .WIDTH(MTW)) u_model_ram (
    .clk  (clk),
    .we   (fin_wr.valid),
    .waddr(AW'(fin_wr.addr)),
    .wdata({fin_wr.mean, fin_wr.th}),
    .re   (acc),
    .raddr(AW'(pixel_in.pixel_addr)),
    .rdata(mt_rdata)
  );

  // Classify
  assign s1_mean   = mt_rdata[MTW-1:gbs_pkg::TH_W];
  assign s1_th     = mt_rdata[gbs_pkg::TH_W-1:0];
  assign diff      = (s1_pix > s1_mean) ? s1_pix - s1_mean : s1_mean - s1_pix;
  assign mask_next = (gbs_pkg::TH_W'(diff) > s1_th) ? gbs_pkg::MASK_FG : gbs_pkg::MASK_BG;

  // Two-entry result queue
  logic [gbs_pkg::MASK_W-1:0] q_mask [2];
  logic [gbs_pkg::ADDR_W-1:0] q_addr [2];
  logic                       q_wptr;
  logic                       q_rptr;

  assign q_push = s1_class;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= '0;
      q_wptr  <= 1'b0;
      q_rptr  <= 1'b0;
    end else begin
      q_count <= q_count + 2'(q_push) - 2'(q_pop);
      if (q_push) q_wptr <= !q_wptr;
      if (q_pop)  q_rptr <= !q_rptr;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mask[q_wptr] <= mask_next;
      q_addr[q_wptr] <= s1_addr;
    end
  end

  assign mask_out.valid      = q_count != 2'd0;
  assign mask_out.mask_value = q_mask[q_rptr];
  assign mask_out.mask_addr  = q_addr[q_rptr];

  // Checks
  a_class_after_final: assert property (@(posedge clk) disable iff (rst)
    s1_class |-> !fin_busy)
    else $error("classify beat overlaps finalize writes");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && !q_pop && q_count == 2'd2))
    else $error("result queue overflow");

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !pixel_in.ready)
    else $error("beat accepted during clearing pass");

endmodule
